// ===== hdl/e2c_pkg.sv =====
`default_nettype none

package e2c_pkg;

  // Pipeline depth: one register stage per entry
  localparam int NUM_STAGES = 8;

  // Seconds to days: t / 86400 = (t >> 7) / 675
  localparam logic [25:0] DAY_RECIP = 26'd50903316;  // floor(2^35 / 675)
  localparam logic [9:0]  DAY_DIV   = 10'd675;

  // Day count rebased to 1968-01-01, the head of a four-year leap cycle
  localparam logic [15:0] EPOCH_TO_1968 = 16'd731;
  // Days from the epoch to 2100-03-01; from there on a phantom Feb 29 is inserted
  localparam logic [15:0] MAR_2100      = 16'd47541;
  localparam logic [15:0] QUAD_RECIP    = 16'd45934;  // ceil(2^26 / 1461)
  localparam logic [10:0] QUAD_DAYS     = 11'd1461;
  localparam logic [11:0] BASE_YEAR     = 12'd1968;

  // Starts of the second, third and fourth year inside a four-year cycle
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  // Reciprocals for small constant divides
  localparam logic [14:0] RECIP_15 = 15'd17477;  // ceil(2^18 / 15)
  localparam logic [16:0] RECIP_7  = 17'd74899;  // ceil(2^19 / 7)

  // The epoch fell on a Thursday
  localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;

  typedef logic [8:0] doy_t;
  typedef logic [3:0] mon_idx_t;

  // First day of each month within a common year, zero based
  localparam doy_t MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // First day of a month; months past February shift by one in a leap year
  function automatic doy_t month_start(input mon_idx_t idx, input logic leap);
    doy_t base;
    base = '0;
    if (idx < 4'd12) begin
      base = MONTH_START[idx];
    end
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Per-stage load enables and occupancy of the pipeline
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] valid;
  } flow_t;

endpackage

`default_nettype wire

// ===== hdl/epoch_seconds_to_calendar_unit.sv =====
`default_nettype none

// Epoch seconds to calendar date and time of day.
//
// Input channel: in_valid / in_stall with in_epoch_seconds, an unsigned count
// of seconds since 1970-01-01 00:00:00. Output channel: out_valid / out_stall
// with year, month, day of month, hour, minute, second and weekday
// (0 = Sunday). A transfer happens on a clock edge where valid is high and
// stall is low. Every input transfer yields exactly one output transfer, in order.
//
// out_valid rises once an input transfer has moved through register stages 0
// to 7. The eight register stages each hold one item, so one item per cycle
// is sustained while out_stall is low; the per-stage load enables let bubbles
// close up while the output is held.
// When out_stall holds a result, earlier stages keep filling; in_stall rises
// only once all eight stages hold items.
//
// Reset (rst_n low, synchronous) empties the pipeline; items in flight are
// dropped and out_valid is low on the next cycle.
module epoch_seconds_to_calendar_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       out_weekday
);

  localparam int N = e2c_pkg::NUM_STAGES;

  e2c_pkg::flow_t flow;

  e2c_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .flow      (flow)
  );

  assign in_stall  = !flow.en[0];
  assign out_valid = flow.valid[N-1];

  // Stage 0: estimate of whole days, exact or one low
  logic [50:0] day_prod;
  logic [31:0] s0_secs_r;
  logic [15:0] s0_est_r;

  assign day_prod = {26'd0, in_epoch_seconds[31:7]} * {25'd0, e2c_pkg::DAY_RECIP};

  always_ff @(posedge clk) begin
    if (flow.en[0]) begin
      s0_secs_r <= in_epoch_seconds;
      s0_est_r  <= day_prod[50:35];
    end
  end

  // Stage 1: multiply the estimate back
  logic [25:0] s1_back_r;
  logic [31:0] s1_secs_r;
  logic [15:0] s1_est_r;

  always_ff @(posedge clk) begin
    if (flow.en[1]) begin
      s1_secs_r <= s0_secs_r;
      s1_est_r  <= s0_est_r;
      s1_back_r <= {10'd0, s0_est_r} * {16'd0, e2c_pkg::DAY_DIV};
    end
  end

  // Stage 2: correct the day count and form the seconds of the day
  logic [25:0] day_rem;
  logic [10:0] day_rem_lo;
  logic        day_fix;
  logic [10:0] day_rem_fix;
  logic [15:0] s2_days_r;
  logic [16:0] s2_sod_r;

  assign day_rem     = {1'b0, s1_secs_r[31:7]} - s1_back_r;
  assign day_rem_lo  = day_rem[10:0];
  assign day_fix     = day_rem_lo >= {1'b0, e2c_pkg::DAY_DIV};
  assign day_rem_fix = day_fix ? (day_rem_lo - {1'b0, e2c_pkg::DAY_DIV}) : day_rem_lo;

  always_ff @(posedge clk) begin
    if (flow.en[2]) begin
      s2_days_r <= s1_est_r + {15'd0, day_fix};
      s2_sod_r  <= {day_rem_fix[9:0], s1_secs_r[6:0]};
    end
  end

  // Stage 3: four-year cycle, minute of the day and week quotients
  logic [15:0] shift_days;
  logic [31:0] quad_prod;
  logic [29:0] min_prod;
  logic [15:0] wk_days;
  logic [32:0] wk_prod;
  logic [15:0] s3_shift_r;
  logic [5:0]  s3_cyc_r;
  logic [10:0] s3_mod_r;
  logic [16:0] s3_sod_r;
  logic [15:0] s3_wk_r;
  logic [12:0] s3_wq_r;

  // Insert a phantom Feb 29 for dates from March 2100 on, keeping cycles uniform
  assign shift_days = s2_days_r + e2c_pkg::EPOCH_TO_1968
                    + {15'd0, (s2_days_r >= e2c_pkg::MAR_2100)};
  assign quad_prod  = {16'd0, shift_days} * {16'd0, e2c_pkg::QUAD_RECIP};
  assign min_prod   = {15'd0, s2_sod_r[16:2]} * {15'd0, e2c_pkg::RECIP_15};
  assign wk_days    = s2_days_r + {13'd0, e2c_pkg::EPOCH_WEEKDAY};
  assign wk_prod    = {17'd0, wk_days} * {16'd0, e2c_pkg::RECIP_7};

  always_ff @(posedge clk) begin
    if (flow.en[3]) begin
      s3_shift_r <= shift_days;
      s3_cyc_r   <= quad_prod[31:26];
      s3_mod_r   <= min_prod[28:18];
      s3_sod_r   <= s2_sod_r;
      s3_wk_r    <= wk_days;
      s3_wq_r    <= wk_prod[31:19];
    end
  end

  // Stage 4: remainders of the day in cycle, second and weekday
  logic [15:0] quad_base;
  logic [15:0] quad_rem;
  logic [16:0] min_base;
  logic [16:0] sec_diff;
  logic [15:0] wk_base;
  logic [15:0] wk_diff;
  logic [10:0] s4_rem_r;
  logic [5:0]  s4_cyc_r;
  logic [10:0] s4_mod_r;
  logic [5:0]  s4_sec_r;
  logic [2:0]  s4_wday_r;

  assign quad_base = {10'd0, s3_cyc_r} * {5'd0, e2c_pkg::QUAD_DAYS};
  assign quad_rem  = s3_shift_r - quad_base;
  assign min_base  = {s3_mod_r, 6'd0} - {4'd0, s3_mod_r, 2'd0};
  assign sec_diff  = s3_sod_r - min_base;
  assign wk_base   = {s3_wq_r, 3'd0} - {3'd0, s3_wq_r};
  assign wk_diff   = s3_wk_r - wk_base;

  always_ff @(posedge clk) begin
    if (flow.en[4]) begin
      s4_rem_r  <= quad_rem[10:0];
      s4_cyc_r  <= s3_cyc_r;
      s4_mod_r  <= s3_mod_r;
      s4_sec_r  <= sec_diff[5:0];
      s4_wday_r <= wk_diff[2:0];
    end
  end

  // Stage 5: year within the cycle, day of year, hour
  logic [1:0]  yoff;
  logic [10:0] year_base;
  logic [10:0] doy_full;
  logic [23:0] hr_prod;
  logic [1:0]  s5_yoff_r;
  e2c_pkg::doy_t s5_doy_r;
  logic [5:0]  s5_cyc_r;
  logic [4:0]  s5_hour_r;
  logic [10:0] s5_mod_r;
  logic [5:0]  s5_sec_r;
  logic [2:0]  s5_wday_r;

  // The leap year leads each cycle
  always_comb begin
    if (s4_rem_r < e2c_pkg::YEAR1_START) begin
      yoff      = 2'd0;
      year_base = '0;
    end else if (s4_rem_r < e2c_pkg::YEAR2_START) begin
      yoff      = 2'd1;
      year_base = e2c_pkg::YEAR1_START;
    end else if (s4_rem_r < e2c_pkg::YEAR3_START) begin
      yoff      = 2'd2;
      year_base = e2c_pkg::YEAR2_START;
    end else begin
      yoff      = 2'd3;
      year_base = e2c_pkg::YEAR3_START;
    end
  end

  assign doy_full = s4_rem_r - year_base;
  assign hr_prod  = {15'd0, s4_mod_r[10:2]} * {9'd0, e2c_pkg::RECIP_15};

  always_ff @(posedge clk) begin
    if (flow.en[5]) begin
      s5_yoff_r <= yoff;
      s5_doy_r  <= doy_full[8:0];
      s5_cyc_r  <= s4_cyc_r;
      s5_hour_r <= hr_prod[22:18];
      s5_mod_r  <= s4_mod_r;
      s5_sec_r  <= s4_sec_r;
      s5_wday_r <= s4_wday_r;
    end
  end

  // Stage 6: year number, month index, minute
  logic              leap;
  e2c_pkg::mon_idx_t mon_cnt;
  logic [10:0]       hr_base;
  logic [10:0]       min_diff;
  logic [11:0]       s6_year_r;
  logic              s6_leap_r;
  e2c_pkg::mon_idx_t s6_mon_r;
  e2c_pkg::doy_t     s6_doy_r;
  logic [4:0]        s6_hour_r;
  logic [5:0]        s6_min_r;
  logic [5:0]        s6_sec_r;
  logic [2:0]        s6_wday_r;

  assign leap = (s5_yoff_r == 2'd0);

  // Count month starts at or before the day of year
  always_comb begin
    mon_cnt = '0;
    for (int m = 1; m < 12; m++) begin
      if (s5_doy_r >= e2c_pkg::month_start(4'(m), leap)) begin
        mon_cnt = mon_cnt + 4'd1;
      end
    end
  end

  assign hr_base  = {s5_hour_r, 6'd0} - {4'd0, s5_hour_r, 2'd0};
  assign min_diff = s5_mod_r - hr_base;

  always_ff @(posedge clk) begin
    if (flow.en[6]) begin
      s6_year_r <= e2c_pkg::BASE_YEAR + {4'd0, s5_cyc_r, 2'd0} + {10'd0, s5_yoff_r};
      s6_leap_r <= leap;
      s6_mon_r  <= mon_cnt;
      s6_doy_r  <= s5_doy_r;
      s6_hour_r <= s5_hour_r;
      s6_min_r  <= min_diff[5:0];
      s6_sec_r  <= s5_sec_r;
      s6_wday_r <= s5_wday_r;
    end
  end

  // Stage 7: output register with month and day of month
  e2c_pkg::doy_t day_diff;
  logic [11:0]   out_year_r;
  logic [3:0]    out_month_r;
  logic [4:0]    out_day_r;
  logic [4:0]    out_hour_r;
  logic [5:0]    out_minute_r;
  logic [5:0]    out_second_r;
  logic [2:0]    out_weekday_r;

  assign day_diff = s6_doy_r - e2c_pkg::month_start(s6_mon_r, s6_leap_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (flow.en[7]) begin
      out_year_r    <= s6_year_r;
      out_month_r   <= s6_mon_r + 4'd1;
      out_day_r     <= day_diff[4:0];
      out_hour_r    <= s6_hour_r;
      out_minute_r  <= s6_min_r;
      out_second_r  <= s6_sec_r;
      out_weekday_r <= s6_wday_r;
    end
  end

  assign out_year         = out_year_r;
  assign out_month        = out_month_r;
  assign out_day_of_month = out_day_r;
  assign out_hour         = out_hour_r;
  assign out_minute       = out_minute_r;
  assign out_second       = out_second_r;
  assign out_weekday      = out_weekday_r;

endmodule

`default_nettype wire

// ===== hdl/e2c_flow.sv =====
`default_nettype none

module e2c_flow (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          out_stall,
  output e2c_pkg::flow_t     flow
);

  localparam int N = e2c_pkg::NUM_STAGES;

  logic [N-1:0] valid_r;
  logic [N-1:0] en;

  // A stage loads when it is empty or when the stage after it moves on
  always_comb begin
    en[N-1] = !valid_r[N-1] || !out_stall;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  // Advance the valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (en[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

  assign flow.en    = en;
  assign flow.valid = valid_r;

endmodule

`default_nettype wire

// ===== hdl/e2c_checker.sv =====
`default_nettype none

module e2c_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [11:0] out_year,
  input wire logic [3:0]  out_month,
  input wire logic [4:0]  out_day_of_month,
  input wire logic [4:0]  out_hour,
  input wire logic [5:0]  out_minute,
  input wire logic [5:0]  out_second,
  input wire logic [2:0]  out_weekday
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_day_of_month) && $stable(out_hour) && $stable(out_minute)
      && $stable(out_second) && $stable(out_weekday))
    else $error("stalled result changed");

  // Push back on input only when the full pipeline is held by the receiver
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Empty pipeline after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented after reset");

  // Keep every delivered field inside its calendar range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_year >= 12'd1970 && out_year <= 12'd2106
      && out_month >= 4'd1 && out_month <= 4'd12
      && out_day_of_month >= 5'd1 && out_hour <= 5'd23
      && out_minute <= 6'd59 && out_second <= 6'd59 && out_weekday <= 3'd6)
    else $error("result field out of range");

  // February never runs past day 29
  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_month == 4'd2 |-> out_day_of_month <= 5'd29)
    else $error("February day out of range");

endmodule

bind epoch_seconds_to_calendar_unit e2c_checker u_e2c_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_year         (out_year),
  .out_month        (out_month),
  .out_day_of_month (out_day_of_month),
  .out_hour         (out_hour),
  .out_minute       (out_minute),
  .out_second       (out_second),
  .out_weekday      (out_weekday)
);

`default_nettype wire

// ===== verif/tb_epoch_seconds_to_calendar_unit.sv =====
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar_unit;

  localparam int unsigned SECONDS_PER_DAY  = 86400;
  localparam int unsigned SECONDS_PER_HOUR = 3600;
  localparam int unsigned SECONDS_PER_MIN  = 60;
  localparam int unsigned FIRST_YEAR       = 1970;
  localparam int unsigned THURSDAY         = 4;
  localparam int unsigned LAST_DAY         = 49710;  // 2106-02-07, where the count runs out
  localparam int          WATCHDOG_LIMIT   = 4000;
  localparam int          ITEMS_PER_PHASE  = 390;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } date_time_t;

  typedef struct packed {
    logic [31:0] stamp;
    date_time_t  date;
  } pending_date_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;

  pending_date_t pending_dates[$];
  int            error_count;
  int            quiet_cycles;
  int            send_idle_pct;
  int            stall_pct;

  // Days since the epoch of dates around leap days and year ends
  int unsigned notable_days[10] = '{59, 789, 1095, 10956, 11016, 11323,
                                    47481, 47540, 47541, 49709};

  epoch_seconds_to_calendar_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday)
  );

  always #6 clk = ~clk;

  function automatic bit leap_year(input int unsigned yr);
    return ((yr % 4) == 0) && (((yr % 100) != 0) || ((yr % 400) == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned mon, input bit leap);
    case (mon)
      2:              return leap ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // Walk years, then months, from the epoch to the calendar date
  function automatic date_time_t predict_calendar(input logic [31:0] stamp);
    date_time_t  res;
    int unsigned day_count;
    int unsigned sec_of_day;
    int unsigned yr;
    int unsigned mon;
    int unsigned span;
    bit          leap;
    day_count   = stamp / SECONDS_PER_DAY;
    sec_of_day  = stamp % SECONDS_PER_DAY;
    res.weekday = 3'((day_count + THURSDAY) % 7);
    res.hour    = 5'(sec_of_day / SECONDS_PER_HOUR);
    res.minute  = 6'((sec_of_day % SECONDS_PER_HOUR) / SECONDS_PER_MIN);
    res.second  = 6'(sec_of_day % SECONDS_PER_MIN);
    yr   = FIRST_YEAR;
    span = leap_year(yr) ? 366 : 365;
    while (day_count >= span) begin
      day_count -= span;
      yr++;
      span = leap_year(yr) ? 366 : 365;
    end
    leap = leap_year(yr);
    mon  = 1;
    span = month_length(mon, leap);
    while ((mon < 12) && (day_count >= span)) begin
      day_count -= span;
      mon++;
      span = month_length(mon, leap);
    end
    res.year  = 12'(yr);
    res.month = 4'(mon);
    res.mday  = 5'(day_count + 1);
    return res;
  endfunction

  // Mix plain random counts with dates near day, month and year edges
  function automatic logic [31:0] pick_timestamp();
    longint      stamp;
    int unsigned day_num;
    int unsigned sec_of_day;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      return $urandom;
    end
    if (pick < 70) begin
      day_num = $urandom_range(LAST_DAY);
    end else begin
      day_num = notable_days[$urandom_range(9)] + $urandom_range(6) - 3;
    end
    case ($urandom_range(4))
      0:       sec_of_day = 0;
      1:       sec_of_day = SECONDS_PER_DAY - 1;
      default: sec_of_day = $urandom_range(SECONDS_PER_DAY - 1);
    endcase
    stamp = longint'(day_num) * SECONDS_PER_DAY + sec_of_day;
    if (stamp > 64'hFFFF_FFFF) begin
      stamp = 64'hFFFF_FFFF - $urandom_range(SECONDS_PER_DAY);
    end
    return stamp[31:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] stamp,
                             input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("seconds %0d %s got %0d want %0d", stamp, name, got, want));
    end
  endtask

  // Drive one timestamp, with random idle cycles ahead of it, and record its date
  task automatic send_timestamp(input logic [31:0] stamp);
    pending_date_t entry;
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= stamp;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    entry.stamp = stamp;
    entry.date  = predict_calendar(stamp);
    pending_dates.push_back(entry);
    @(negedge clk);
  endtask

  task automatic send_date(input int unsigned day_num, input int unsigned sec_of_day);
    send_timestamp(32'(day_num * SECONDS_PER_DAY + sec_of_day));
  endtask

  // Epoch, end of range, leap days, year ends and the 2100 non-leap February
  task automatic test_calendar_edges();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_timestamp(32'd0);
    send_timestamp(32'd59);
    send_timestamp(32'd3599);
    send_timestamp(32'd86399);
    send_timestamp(32'd86400);
    send_timestamp(32'hFFFF_FFFF);
    send_timestamp(32'h7FFF_FFFF);
    send_timestamp(32'h8000_0000);
    send_timestamp(32'h5555_5555);
    send_timestamp(32'hAAAA_AAAA);
    send_date(364, 86399);
    send_date(365, 0);
    send_date(788, 86399);
    send_date(789, 43200);
    send_date(790, 0);
    send_date(1095, 86399);
    send_date(10956, 86399);
    send_date(11016, 45296);
    send_date(11322, 86399);
    send_date(47481, 86399);
    send_date(47540, 86399);
    send_date(47541, 0);
    send_date(LAST_DAY, 23295);
  endtask

  task automatic test_streaming(input int send_pct, input int stall_level, input int count);
    send_idle_pct = send_pct;
    stall_pct     = stall_level;
    repeat (count) begin
      send_timestamp(pick_timestamp());
    end
  endtask

  // Hold the input off until the pipeline has emptied, then resume back to back
  task automatic test_pause_until_drained();
    send_idle_pct = 0;
    stall_pct     = 33;
    repeat (20) begin
      send_timestamp(pick_timestamp());
    end
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) begin
      send_timestamp(pick_timestamp());
    end
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Compare each result transfer with the oldest recorded date
  always @(posedge clk) begin : check_result
    pending_date_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result with no input waiting");
      end else begin
        want = pending_dates.pop_front();
        check_field("year", want.stamp, out_year, want.date.year);
        check_field("month", want.stamp, out_month, want.date.month);
        check_field("day_of_month", want.stamp, out_day_of_month, want.date.mday);
        check_field("hour", want.stamp, out_hour, want.date.hour);
        check_field("minute", want.stamp, out_minute, want.date.minute);
        check_field("second", want.stamp, out_second, want.date.second);
        check_field("weekday", want.stamp, out_weekday, want.date.weekday);
      end
    end
  end

  // Abort if no transfer happens on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    out_stall        = 1'b0;
    error_count      = 0;
    quiet_cycles     = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_calendar_edges();
    test_streaming(0, 0, ITEMS_PER_PHASE);
    test_streaming(82, 0, ITEMS_PER_PHASE);
    test_pause_until_drained();
    test_streaming(0, 82, ITEMS_PER_PHASE);
    test_streaming(33, 33, ITEMS_PER_PHASE);

    // Drain the pipeline with the receiver always ready
    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending_dates.size() != 0) begin
      @(negedge clk);
    end
    repeat (e2c_pkg::NUM_STAGES + 4) @(negedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
